// ----- hw/rtl/tcpwg_pkg.sv -----
// Shared types and constants for the TCP receive window granter.
// Holds the transaction payload structs, the flow table entry and the sequencer states.
// No dependencies.
package tcpwg_pkg;

   localparam int unsigned FLOW_SLOTS_DEFAULT = 1024;
   // Slot compare width: holds any slot number and the largest table depth
   localparam int unsigned SLOT_EXT_W         = 17;
   localparam logic [31:0] ACCOUNTING_MARK    = 32'hFFFF_FFFF;
   localparam logic [15:0] MIN_GRANT_RESET    = 16'd1448;

   typedef enum logic [1:0] {
      CMD_PACKET  = 2'd0,
      CMD_INSTALL = 2'd1,
      CMD_GRANT   = 2'd2,
      CMD_REMOVE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [9:0]         flow_slot;
      logic [31:0]        ack_seq;
      logic [15:0]        window_in;
      logic [30:0]        grant_bytes;
      logic               pregrant;
      logic signed [31:0] ungranted_in;
      logic [31:0]        override_in;
      logic [3:0]         scale_in;
      logic signed [31:0] end_buffer_in;
   } req_type;

   typedef struct packed {
      logic [15:0] window_out;
      logic        grant_done_event;
      logic [9:0]  flow_slot_out;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        marks_set;
      logic        done;
      logic        pend_pre;
      logic [3:0]  scale;
      logic [30:0] pend_grant;
      logic [31:0] override_win;
      logic [31:0] ungranted;
      logic [31:0] window_end;
      logic [31:0] grant_end;
      logic [31:0] end_buffer;
   } flow_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_GRANT,
      ST_APPLY,
      ST_WIN,
      ST_PAD_SEG,
      ST_PAD_SCALE,
      ST_EXTRA_APPLY,
      ST_EXTRA_GRANT,
      ST_DIST,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/tcpwg_table.sv -----
// Flow table memory: one entry per slot, one write port, one registered read port.
// Runs a clearing pass of the valid bits after reset. Depends on tcpwg_pkg.
module tcpwg_table #(
   parameter int unsigned FLOW_SLOTS = tcpwg_pkg::FLOW_SLOTS_DEFAULT,
   localparam int unsigned SLOT_W    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [SLOT_W-1:0]         rd_addr,
   output tcpwg_pkg::flow_entry_type rd_data,
   input  logic                      wr_en,
   input  logic [SLOT_W-1:0]         wr_addr,
   input  tcpwg_pkg::flow_entry_type wr_data,
   output logic                      clear_busy
);

   tcpwg_pkg::flow_entry_type entry_mem_ff [FLOW_SLOTS];
   tcpwg_pkg::flow_entry_type rd_data_ff;

   logic              clearing_ff, clearing_in;
   logic [SLOT_W-1:0] clear_idx_ff, clear_idx_in;

   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr;
   tcpwg_pkg::flow_entry_type mem_wdata;

   always_comb begin
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      if (clearing_ff) begin
         if (clear_idx_ff == SLOT_W'(FLOW_SLOTS - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clear_idx_in = clear_idx_ff + SLOT_W'(1);
         end
      end
   end

   // The sweep owns the write port until every entry reads as invalid
   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule

// ----- hw/rtl/tcp_receive_window_granter.sv -----
// Top level of the TCP receive window granter: sequencer and grant arithmetic
// around the flow table. Depends on tcpwg_pkg and tcpwg_table.
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-------------------------
//  request | req_valid req_ready req_data   | in        | tcpwg_pkg::req_type
//  response| rsp_valid rsp_ready rsp_data   | out       | tcpwg_pkg::rsp_type
//  csr     | csr_wr_en csr_wr_data          | in        | min_grant_bytes, 16 bits
//
// Install, post grant and remove end in lookup; an override-flow packet goes to the
// final step, an accounted one first through grant, apply, window, both pads and
// distance. One transaction is in the sequencer at a time; every step is a read, one
// arithmetic step on the held entry, or the write-back. After reset req_ready stays
// low while the table clears its valid bits. A response waits in the output
// register; the next transaction stalls in its final step only while that is full.
module tcp_receive_window_granter #(
   parameter int unsigned FLOW_SLOTS = tcpwg_pkg::FLOW_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcpwg_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcpwg_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   localparam int unsigned SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

   tcpwg_pkg::state_type      state_ff, state_in;
   tcpwg_pkg::req_type        req_ff, req_in;
   tcpwg_pkg::flow_entry_type ent_ff, ent_in;
   logic [31:0]               take_ff, take_in;
   logic [31:0]               normal_ff, normal_in;
   logic [31:0]               win_ff, win_in;
   logic [31:0]               extra_ff, extra_in;
   logic [31:0]               dist_ff, dist_in;
   logic                      step_pre_ff, step_pre_in;
   logic                      pad_ok_ff, pad_ok_in;
   logic                      pad_go_ff, pad_go_in;
   logic                      scale_phase_ff, scale_phase_in;
   logic                      accounting_ff, accounting_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tcpwg_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic [15:0]               min_grant_ff, min_grant_in;

   logic [tcpwg_pkg::SLOT_EXT_W-1:0] slot_ext;
   logic                             slot_in_range;
   logic [SLOT_W-1:0]                rd_addr;
   logic [SLOT_W-1:0]                wr_addr;
   tcpwg_pkg::flow_entry_type        rd_data;
   logic                             fsm_wr_en;
   tcpwg_pkg::flow_entry_type        fsm_wr_data;
   logic                             clear_busy;

   assign slot_ext      = tcpwg_pkg::SLOT_EXT_W'(req_data.flow_slot);
   assign slot_in_range = slot_ext < tcpwg_pkg::SLOT_EXT_W'(FLOW_SLOTS);
   assign rd_addr       = slot_ext[SLOT_W-1:0];
   assign wr_addr       = SLOT_W'(req_ff.flow_slot);

   tcpwg_table #(
      .FLOW_SLOTS(FLOW_SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (fsm_wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (fsm_wr_data),
      .clear_busy (clear_busy)
   );

   always_comb begin
      min_grant_in = min_grant_ff;
      if (csr_wr_en) begin
         min_grant_in = csr_wr_data;
      end
   end

   always_comb begin
      logic [31:0] pos;
      logic [31:0] total;
      logic [31:0] normal;
      logic [31:0] min32;
      logic [31:0] unit;
      logic [31:0] gap;
      logic [31:0] scaled;
      logic        hit;
      logic        can_load;

      state_in       = state_ff;
      req_in         = req_ff;
      ent_in         = ent_ff;
      take_in        = take_ff;
      normal_in      = normal_ff;
      win_in         = win_ff;
      extra_in       = extra_ff;
      dist_in        = dist_ff;
      step_pre_in    = step_pre_ff;
      pad_ok_in      = pad_ok_ff;
      pad_go_in      = pad_go_ff;
      scale_phase_in = scale_phase_ff;
      accounting_in  = accounting_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      req_ready      = 1'b0;
      fsm_wr_en      = 1'b0;
      fsm_wr_data    = ent_ff;

      // positive part of the signed ungranted count
      pos      = (!ent_ff.ungranted[31] && (ent_ff.ungranted != '0)) ? ent_ff.ungranted : '0;
      total    = {1'b0, ent_ff.pend_grant};
      normal   = (total < pos) ? total : pos;
      min32    = {16'd0, min_grant_ff};
      unit     = 32'd1 << ent_ff.scale;
      gap      = dist_ff - req_ff.ack_seq;
      hit      = accounting_ff && ((gap == '0) || gap[31]) && !ent_ff.done;
      scaled   = win_ff >> ent_ff.scale;
      can_load = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         tcpwg_pkg::ST_IDLE: begin
            req_ready = !clear_busy;
            if (req_valid && !clear_busy) begin
               req_in = req_data;
               // drop transactions for slots beyond the table
               if (slot_in_range) begin
                  state_in = tcpwg_pkg::ST_LOOKUP;
               end
            end
         end
         tcpwg_pkg::ST_LOOKUP: begin
            state_in = tcpwg_pkg::ST_IDLE;
            unique case (req_ff.cmd)
               tcpwg_pkg::CMD_INSTALL: begin
                  fsm_wr_en                = 1'b1;
                  fsm_wr_data              = '0;
                  fsm_wr_data.valid        = 1'b1;
                  fsm_wr_data.scale        = req_ff.scale_in;
                  fsm_wr_data.override_win = req_ff.override_in;
                  fsm_wr_data.ungranted    = 32'(unsigned'(req_ff.ungranted_in));
                  fsm_wr_data.end_buffer   = 32'(unsigned'(req_ff.end_buffer_in));
               end
               tcpwg_pkg::CMD_GRANT: begin
                  fsm_wr_en              = rd_data.valid;
                  fsm_wr_data            = rd_data;
                  fsm_wr_data.pend_grant = req_ff.grant_bytes;
                  fsm_wr_data.pend_pre   = req_ff.pregrant;
               end
               tcpwg_pkg::CMD_REMOVE: begin
                  fsm_wr_en         = 1'b1;
                  fsm_wr_data       = rd_data;
                  fsm_wr_data.valid = 1'b0;
               end
               tcpwg_pkg::CMD_PACKET: begin
                  ent_in = rd_data;
                  if (rd_data.valid) begin
                     if (rd_data.override_win == tcpwg_pkg::ACCOUNTING_MARK) begin
                        accounting_in = 1'b1;
                        state_in      = tcpwg_pkg::ST_GRANT;
                     end else begin
                        accounting_in = 1'b0;
                        win_in        = rd_data.override_win;
                        state_in      = tcpwg_pkg::ST_FINISH;
                     end
                  end
               end
            endcase
         end
         tcpwg_pkg::ST_GRANT: begin
            if (!ent_ff.marks_set) begin
               ent_in.marks_set  = 1'b1;
               ent_in.grant_end  = req_ff.ack_seq;
               ent_in.window_end = req_ff.ack_seq;
            end
            if (ent_ff.pend_grant != '0) begin
               step_pre_in       = ent_ff.pend_pre;
               normal_in         = normal;
               take_in           = ent_ff.pend_pre ? total : normal;
               ent_in.pend_grant = '0;
               ent_in.pend_pre   = 1'b0;
            end else begin
               step_pre_in = 1'b0;
               normal_in   = '0;
               take_in     = '0;
            end
            state_in = tcpwg_pkg::ST_APPLY;
         end
         tcpwg_pkg::ST_APPLY: begin
            ent_in.ungranted  = ent_ff.ungranted - take_ff;
            ent_in.window_end = ent_ff.window_end + take_ff;
            ent_in.grant_end  = ent_ff.grant_end + normal_ff;
            state_in          = tcpwg_pkg::ST_WIN;
         end
         tcpwg_pkg::ST_WIN: begin
            win_in    = ent_ff.window_end - req_ff.ack_seq;
            pad_ok_in = !step_pre_ff && ($signed(ent_ff.ungranted) <= 32'sd0);
            state_in  = tcpwg_pkg::ST_PAD_SEG;
         end
         tcpwg_pkg::ST_PAD_SEG: begin
            // padding is decided once, before either pad step grows the window
            pad_go_in      = pad_ok_ff && (win_ff != '0);
            scale_phase_in = 1'b0;
            if (pad_ok_ff && (win_ff != '0) && (win_ff < min32)) begin
               extra_in = min32 - win_ff;
               win_in   = min32;
            end else begin
               extra_in = '0;
            end
            state_in = tcpwg_pkg::ST_EXTRA_APPLY;
         end
         tcpwg_pkg::ST_PAD_SCALE: begin
            scale_phase_in = 1'b1;
            if (pad_go_ff && (win_ff < unit)) begin
               extra_in = unit - win_ff;
               win_in   = unit;
            end else begin
               extra_in = '0;
            end
            state_in = tcpwg_pkg::ST_EXTRA_APPLY;
         end
         tcpwg_pkg::ST_EXTRA_APPLY: begin
            ent_in.ungranted  = ent_ff.ungranted - extra_ff;
            ent_in.window_end = ent_ff.window_end + extra_ff;
            state_in          = tcpwg_pkg::ST_EXTRA_GRANT;
         end
         tcpwg_pkg::ST_EXTRA_GRANT: begin
            // advance the grant end only by what is still ungranted
            ent_in.grant_end = ent_ff.grant_end + ((extra_ff < pos) ? extra_ff : pos);
            state_in = scale_phase_ff ? tcpwg_pkg::ST_DIST : tcpwg_pkg::ST_PAD_SCALE;
         end
         tcpwg_pkg::ST_DIST: begin
            dist_in  = ent_ff.grant_end - ent_ff.end_buffer;
            state_in = tcpwg_pkg::ST_FINISH;
         end
         tcpwg_pkg::ST_FINISH: begin
            if (can_load) begin
               fsm_wr_en                    = 1'b1;
               fsm_wr_data.done             = ent_ff.done || hit;
               rsp_valid_in                 = 1'b1;
               rsp_data_in.window_out       = (req_ff.window_in < scaled[15:0]) ?
                                              req_ff.window_in : scaled[15:0];
               rsp_data_in.grant_done_event = hit;
               rsp_data_in.flow_slot_out    = req_ff.flow_slot;
               state_in                     = tcpwg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcpwg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcpwg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_grant_ff <= tcpwg_pkg::MIN_GRANT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_grant_ff <= min_grant_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      ent_ff         <= ent_in;
      take_ff        <= take_in;
      normal_ff      <= normal_in;
      win_ff         <= win_in;
      extra_ff       <= extra_in;
      dist_ff        <= dist_in;
      step_pre_ff    <= step_pre_in;
      pad_ok_ff      <= pad_ok_in;
      pad_go_ff      <= pad_go_in;
      scale_phase_ff <= scale_phase_in;
      accounting_ff  <= accounting_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tcpwg_pkg::ST_FINISH))
      else $error("response raised outside the final step");

   a_no_write_during_clear: assert property (@(posedge clock) disable iff (reset)
      fsm_wr_en |-> !clear_busy)
      else $error("table write while the clearing pass runs");

   a_lookup_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcpwg_pkg::ST_LOOKUP) |-> $past(req_valid && req_ready))
      else $error("lookup without an accepted transaction");

   a_event_only_accounted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcpwg_pkg::ST_FINISH && !accounting_ff && rsp_valid_in && !rsp_valid_ff)
      |=> !rsp_data_ff.grant_done_event)
      else $error("done event on an override flow");

endmodule
